FILE: sv/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder package
// Types, constants and the character lookup shared by the decoder modules.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Width of the capacity register and of the emitted-byte counter.
  localparam int unsigned CapW   = 13;
  localparam int unsigned CountW = 12;

  // Reset capacity and the byte limit that follows from it.
  localparam logic [CapW-1:0]   CapacityReset = 13'd256;
  localparam logic [CountW-1:0] LimitReset    = 12'd255;
  localparam logic [CapW-1:0]   CapacityTop   = 13'd4096;
  localparam logic [CountW-1:0] LimitMax      = 12'hFFF;

  // Positions inside a group of four characters.
  localparam logic [1:0] PosFirst = 2'd0;
  localparam logic [1:0] PosThird = 2'd2;
  localparam logic [1:0] PosLast  = 2'd3;

  // Byte counts that one group can yield.
  localparam logic [1:0] BytesNone  = 2'd0;
  localparam logic [1:0] BytesOne   = 2'd1;
  localparam logic [1:0] BytesTwo   = 2'd2;
  localparam logic [1:0] BytesThree = 2'd3;

  // Character codes.
  localparam logic [7:0] ChPad   = 8'h3D;  // '='
  localparam logic [7:0] ChPlus  = 8'h2B;  // '+'
  localparam logic [7:0] ChSlash = 8'h2F;  // '/'
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7A;
  localparam logic [7:0] ChDig0  = 8'h30;
  localparam logic [7:0] ChDig9  = 8'h39;

  // Classification of one character.
  typedef struct packed {
    logic       ok;    // alphabet character or pad
    logic       pad;   // the pad character
    logic [5:0] val;   // sextet, zero for pad and invalid
  } sextet_t;

  // One group record handed from the front to the back.
  typedef struct packed {
    logic [2:0][7:0] data;  // data[0] is the first byte out
    logic [1:0]      cnt;   // bytes to emit, zero for a bare end marker
    logic            last;  // the record ends the string
    logic            err;   // string was invalid (only with last)
  } rec_t;

  // Map an ASCII code to its sextet.
  function automatic sextet_t b64d_to_sextet(input logic [7:0] c);
    sextet_t    s;
    logic [7:0] diff;
    s    = '0;
    diff = '0;
    if (c >= ChUpA && c <= ChUpZ) begin
      diff  = c - ChUpA;
      s.ok  = 1'b1;
      s.val = diff[5:0];
    end else if (c >= ChLoA && c <= ChLoZ) begin
      diff  = c - ChLoA + 8'd26;
      s.ok  = 1'b1;
      s.val = diff[5:0];
    end else if (c >= ChDig0 && c <= ChDig9) begin
      diff  = c - ChDig0 + 8'd52;
      s.ok  = 1'b1;
      s.val = diff[5:0];
    end else if (c == ChPlus) begin
      s.ok  = 1'b1;
      s.val = 6'd62;
    end else if (c == ChSlash) begin
      s.ok  = 1'b1;
      s.val = 6'd63;
    end else if (c == ChPad) begin
      s.ok  = 1'b1;
      s.pad = 1'b1;
    end
    return s;
  endfunction

endpackage

FILE: sv/b64d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder front end
// Classifies each accepted character, packs sextets into groups, applies the
// pad, error and capacity rules and writes one record per producing step.
// ----------------------------------------------------------------------------
module b64d_front
  import b64d_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      char_in_i,
  input  logic            end_of_string_i,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_data_i,
  output logic            rec_push_o,
  output rec_t            rec_o
);

  logic [17:0]       acc_q, acc_d;
  logic [1:0]        pos_q, pos_d;
  logic              pad3_q, pad3_d;
  logic              fin_q, fin_d;
  logic              err_q, err_d;
  logic [CountW-1:0] be_q, be_d;
  logic [CountW-1:0] limit_q, limit_d;

  sextet_t           sx;
  logic [23:0]       grp;
  logic [1:0]        nb;
  logic [1:0]        n;
  logic              str_err;
  logic [CountW-1:0] avail;
  logic [CapW-1:0]   cap_m1;

  // Byte limit follows the capacity register; it is kept precomputed.
  always_comb begin
    cap_m1 = cfg_data_i - 13'd1;
    if (cfg_data_i == '0) begin
      limit_d = '0;
    end else if (cfg_data_i > CapacityTop) begin
      limit_d = LimitMax;
    end else begin
      limit_d = cap_m1[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= limit_d;
    end
  end

  // Group assembly, pad handling and byte counting for one character.
  always_comb begin
    sx     = b64d_to_sextet(char_in_i);
    acc_d  = acc_q;
    pad3_d = pad3_q;
    fin_d  = fin_q;
    err_d  = err_q;
    grp    = '0;
    nb     = BytesNone;

    if (!fin_q) begin
      err_d = err_q | ~sx.ok;
      if (pos_q != PosLast) begin
        acc_d = {acc_q[11:0], sx.val};
        if (pos_q == PosThird) begin
          pad3_d = sx.pad;
        end
      end else begin
        grp = {acc_q, sx.val};
        if (pad3_q) begin
          nb = BytesOne;
        end else if (sx.pad) begin
          nb = BytesTwo;
        end else begin
          nb = BytesThree;
        end
        fin_d  = pad3_q | sx.pad;
        pad3_d = 1'b0;
        acc_d  = '0;
        if (err_d) begin
          nb = BytesNone;
        end
      end
    end

    pos_d   = pos_q + 2'd1;
    str_err = err_d | (pos_d != PosFirst);
    if (end_of_string_i && str_err) begin
      nb = BytesNone;
    end

    // Clip to the room left under the limit.
    avail = (be_q < limit_q) ? (limit_q - be_q) : '0;
    n     = (avail < {{(CountW-2){1'b0}}, nb}) ? avail[1:0] : nb;
    be_d  = be_q + {{(CountW-2){1'b0}}, n};

    // The final character clears the per-string state.
    if (end_of_string_i) begin
      acc_d  = '0;
      pos_d  = PosFirst;
      pad3_d = 1'b0;
      fin_d  = 1'b0;
      err_d  = 1'b0;
      be_d   = '0;
    end
  end

  // Record toward the back end.
  always_comb begin
    rec_o.data[0] = grp[23:16];
    rec_o.data[1] = grp[15:8];
    rec_o.data[2] = grp[7:0];
    rec_o.cnt     = n;
    rec_o.last    = end_of_string_i;
    rec_o.err     = end_of_string_i & str_err;
    rec_push_o    = accept_i & (end_of_string_i | (n != BytesNone));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pos_q  <= PosFirst;
      pad3_q <= 1'b0;
      fin_q  <= 1'b0;
      err_q  <= 1'b0;
      be_q   <= '0;
    end else if (accept_i) begin
      acc_q  <= acc_d;
      pos_q  <= pos_d;
      pad3_q <= pad3_d;
      fin_q  <= fin_d;
      err_q  <= err_d;
      be_q   <= be_d;
    end
  end

  // A final character leaves the per-string state cleared.
  a_eos_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_string_i |=> pos_q == PosFirst && be_q == '0 && !err_q && !fin_q)
    else $error("string state not cleared after final character");

endmodule

FILE: sv/b64d_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder record queue
// Short queue of group records that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module b64d_fifo
  import b64d_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  rec_t wr_data_i,
  input  logic rd_i,
  output rec_t rd_data_o,
  output logic rd_valid_o,
  output logic full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign do_wr      = wr_i & ~full_o;
  assign do_rd      = rd_i & rd_valid_o;
  assign full_o     = (cnt_q == CntFull);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("record queue occupancy out of range");

endmodule

FILE: sv/b64d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder back end
// Expands each queued record into byte results, one per cycle while not stalled
// by the consumer, into an output register that the consumer pops.
// ----------------------------------------------------------------------------
module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rec_t       head_i,
  input  logic       head_valid_i,
  output logic       head_pop_o,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       last_o,
  output logic       decode_error_o
);

  logic       out_valid_q;
  logic [1:0] idx_q, idx_d;
  logic       load;
  logic       rec_done;
  logic [7:0] data_q, data_d;
  logic       bval_q, bval_d;
  logic       last_q, last_d;
  logic       err_q, err_d;

  // Load a new result when the output register is free or being taken.
  assign load       = head_valid_i & (~out_valid_q | pop);
  assign rec_done   = (head_i.cnt == BytesNone) || (idx_q == head_i.cnt - 2'd1);
  assign head_pop_o = load & rec_done;

  // Result built from the head record at the current byte index.
  always_comb begin
    idx_d = rec_done ? 2'd0 : idx_q + 2'd1;
    if (head_i.cnt == BytesNone) begin
      data_d = '0;
      bval_d = 1'b0;
      last_d = head_i.last;
      err_d  = head_i.err;
    end else begin
      data_d = head_i.data[idx_q];
      bval_d = 1'b1;
      last_d = head_i.last & rec_done;
      err_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= idx_d;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
      bval_q <= bval_d;
      last_q <= last_d;
      err_q  <= err_d;
    end
  end

  assign empty          = ~out_valid_q;
  assign data_byte_o    = data_q;
  assign byte_valid_o   = bval_q;
  assign last_o         = last_q;
  assign decode_error_o = err_q;

  // A partly expanded record stays at the head of the queue.
  a_idx_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> head_valid_i && idx_q < head_i.cnt)
    else $error("byte index past the head record");

  // An error is only ever reported on a bare end marker.
  a_err_marker : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && err_q |-> last_q && !bval_q)
    else $error("decode error on a non-final result");

endmodule

FILE: sv/base64_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes base64 characters into bytes with pad, error and capacity handling.
// ----------------------------------------------------------------------------
// The decoder takes one character per clock cycle, sustained, and stalls the
// input only while its four-entry record queue is full. Each group of four
// characters that yields bytes, or each final character, becomes one record
// in the front end; the back end turns a record into up to three results at
// one per cycle while the consumer pops, so a string yields at most one
// result per character and the queue does not fill while the consumer keeps
// up. The first result of a group passes the record queue and then the
// output register after its fourth character is accepted. That register
// holds the oldest result while empty is low. The capacity register is
// written through the configuration channel, which is always ready, and must
// only be written while no transaction is in flight.
module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // Character queue side
  input  logic            push,
  output logic            full,
  input  logic [7:0]      char_in_i,
  input  logic            end_of_string_i,
  // Result queue side
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      data_byte_o,
  output logic            byte_valid_o,
  output logic            last_o,
  output logic            decode_error_o,
  // Capacity register write
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CapW-1:0] cfg_data_i
);

  logic accept;
  logic cfg_we;
  logic rec_push;
  rec_t rec;
  rec_t head;
  logic head_valid;
  logic head_pop;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign accept      = push & ~full;

  b64d_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .char_in_i       (char_in_i),
    .end_of_string_i (end_of_string_i),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data_i),
    .rec_push_o      (rec_push),
    .rec_o           (rec)
  );

  b64d_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (rec_push),
    .wr_data_i  (rec),
    .rd_i       (head_pop),
    .rd_data_o  (head),
    .rd_valid_o (head_valid),
    .full_o     (full)
  );

  b64d_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .head_valid_i   (head_valid),
    .head_pop_o     (head_pop),
    .pop            (pop),
    .empty          (empty),
    .data_byte_o    (data_byte_o),
    .byte_valid_o   (byte_valid_o),
    .last_o         (last_o),
    .decode_error_o (decode_error_o)
  );

endmodule
